FILE: rtl/core/dsrc_pkg.sv
// constants, byte kind codes and the crc byte update for the sector record checker
// used by disk_sector_record_checker; no dependencies
package dsrc_pkg;

  // record layout
  localparam int HdrBytes        = 4;
  localparam int LongDataBytes   = 256;
  localparam int ShortDataBytes  = 128;
  localparam int MaxSectorBytesD = 256;

  // crc and data mask constants
  localparam logic [15:0] CrcPoly  = 16'h8408;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [7:0]  DataMask = 8'hB3;

  // format register
  localparam logic [1:0] FmtShort = 2'd2;
  localparam logic [1:0] FmtReset = 2'd1;

  // byte kind codes
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_CRC    = 2'd2
  } byte_kind_t;

  // reflected crc-16 over one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/disk_sector_record_checker.sv
// sector record checker: header/data/crc byte classification and crc-16 check
// depends on dsrc_pkg (constants, kind codes, crc16_byte)
// each accepted byte's result item is registered in the output register
// throughput: one byte per cycle unless the result channel stalls, set by the single crc byte update between registers
// reset (rst, synchronous): position 0, crc 0xFFFF, sector and crc high byte 0,
//   format register 1, output register empty
module disk_sector_record_checker
  import dsrc_pkg::*;
#(
  parameter int MAX_SECTOR_BYTES = MaxSectorBytesD
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  sector_format,
  // input byte channel
  input  logic        rec_valid,
  output logic        rec_ready,
  input  logic [7:0]  rec_byte,
  input  logic        record_start,
  // result channel
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  byte_kind,
  output logic        record_end,
  output logic        crc_ok,
  output logic [7:0]  sector_number,
  output logic [15:0] record_crc,
  output logic [15:0] computed_crc
);

  localparam int DataLong  = (LongDataBytes < MAX_SECTOR_BYTES) ? LongDataBytes
                                                                : MAX_SECTOR_BYTES;
  localparam int DataShort = (ShortDataBytes < MAX_SECTOR_BYTES) ? ShortDataBytes
                                                                 : MAX_SECTOR_BYTES;
  localparam int PosW      = $clog2(MAX_SECTOR_BYTES + HdrBytes + 2);

  localparam logic [PosW-1:0] PosHdr      = PosW'(HdrBytes);
  localparam logic [PosW-1:0] PosCrcLong  = PosW'(HdrBytes + DataLong);
  localparam logic [PosW-1:0] PosCrcShort = PosW'(HdrBytes + DataShort);
  localparam logic [PosW-1:0] PosMax      = PosW'(HdrBytes + DataLong + 1);

  // state
  logic [1:0]      fmt;
  logic [PosW-1:0] byte_position, byte_position_next;
  logic [15:0]     crc_register, crc_register_next;
  logic [7:0]      crc_high_byte, crc_high_byte_next;
  logic [7:0]      sector_number_reg, sector_number_next;

  logic [PosW-1:0] pos_eff, pos_crc;
  logic [15:0]     crc_eff, crc_upd;
  logic [7:0]      ob;
  logic [7:0]      crc_in;
  byte_kind_t      kind;
  logic            fin;
  logic [15:0]     stored;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign rec_ready = !res_valid || res_ready;
  assign accept    = rec_valid && rec_ready;

  // start flag restarts the record before the byte is handled
  assign pos_eff = record_start ? '0 : byte_position;
  assign crc_eff = record_start ? CrcInit : crc_register;
  assign pos_crc = (fmt == FmtShort) ? PosCrcShort : PosCrcLong;

  // classify the byte and pick the crc input
  always_comb begin
    ob     = rec_byte;
    kind   = KIND_HEADER;
    fin    = 1'b0;
    crc_in = rec_byte;
    if (pos_eff < PosHdr) begin
      kind = KIND_HEADER;
    end else if (pos_eff < pos_crc) begin
      ob     = rec_byte ^ DataMask;
      crc_in = ob;
      kind   = KIND_DATA;
    end else if (pos_eff == pos_crc) begin
      kind = KIND_CRC;
    end else begin
      kind = KIND_CRC;
      fin  = 1'b1;
    end
  end

  assign crc_upd = crc16_byte(crc_eff, crc_in);
  assign stored  = {crc_high_byte, rec_byte};

  // next state
  always_comb begin
    byte_position_next = pos_eff + PosW'(1);
    crc_register_next  = crc_eff;
    crc_high_byte_next = crc_high_byte;
    sector_number_next = sector_number_reg;
    case (kind)
      KIND_HEADER: begin
        crc_register_next = crc_upd;
        if (pos_eff == PosHdr - PosW'(1)) begin
          sector_number_next = rec_byte;
        end
      end
      KIND_DATA: begin
        crc_register_next = crc_upd;
      end
      KIND_CRC: begin
        if (!fin) begin
          crc_high_byte_next = rec_byte;
        end
      end
      default: begin
        crc_register_next = crc_eff;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FmtReset;
    end else if (cfg_valid && cfg_ready) begin
      fmt <= sector_format;
    end
  end

  // record state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      crc_register      <= CrcInit;
      crc_high_byte     <= '0;
      sector_number_reg <= '0;
    end else if (accept) begin
      byte_position     <= fin ? '0 : byte_position_next;
      crc_register      <= fin ? CrcInit : crc_register_next;
      crc_high_byte     <= crc_high_byte_next;
      sector_number_reg <= sector_number_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte      <= ob;
      byte_kind     <= kind;
      record_end    <= fin;
      crc_ok        <= fin && (stored == crc_eff);
      sector_number <= sector_number_next;
      record_crc    <= fin ? stored : 16'h0000;
      computed_crc  <= crc_register_next;
    end
  end

  // the record ends only on a crc byte, and a pass only with an end
  a_end_is_crc: assert property (@(posedge clk) disable iff (rst)
    res_valid && record_end |-> byte_kind == KIND_CRC)
    else $error("record_end on a byte that is not a crc byte");

  a_ok_needs_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && crc_ok |-> record_end)
    else $error("crc_ok without record_end");

  // after the final crc byte the record state is back at its start
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> byte_position == '0 && crc_register == CrcInit)
    else $error("record state not restarted after final crc byte");

  // position never runs past the final crc byte of the longest record
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= PosMax)
    else $error("byte position past end of record");

endmodule

FILE: dv/tb_disk_sector_record_checker.sv
// testbench for disk_sector_record_checker: sector records, resync, format changes, stalls
// depends on dsrc_pkg and the disk_sector_record_checker rtl; self-checking, no files read
`timescale 1ns / 1ps

module tb_disk_sector_record_checker;
  import dsrc_pkg::*;

  localparam int HOLD_CYCLES  = 64;
  localparam int RANDOM_ITEMS = 30;

  // one result item as the block reports it
  typedef struct {
    logic [7:0]  ob;
    byte_kind_t  kind;
    logic        last;
    logic        ok;
    logic [7:0]  sec;
    logic [15:0] stored;
    logic [15:0] crc;
  } sector_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  sector_format;
  logic        rec_valid;
  logic        rec_ready;
  logic [7:0]  rec_byte;
  logic        record_start;
  logic        res_valid;
  logic        res_ready;
  logic [7:0]  out_byte;
  logic [1:0]  byte_kind;
  logic        record_end;
  logic        crc_ok;
  logic [7:0]  sector_number;
  logic [15:0] record_crc;
  logic [15:0] computed_crc;

  // checker state mirrored from the block
  logic [1:0]     fmt_q;
  int unsigned    pos_q;
  logic [15:0]    crc_q;
  logic [7:0]     crc_hi_q;
  logic [7:0]     sec_q;
  sector_result_t result_q[$];
  int             errors;
  int             sent_items;
  bit             idle_on;
  bit             hold_req;

  disk_sector_record_checker i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .sector_format(sector_format),
    .rec_valid    (rec_valid),
    .rec_ready    (rec_ready),
    .rec_byte     (rec_byte),
    .record_start (record_start),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .out_byte     (out_byte),
    .byte_kind    (byte_kind),
    .record_end   (record_end),
    .crc_ok       (crc_ok),
    .sector_number(sector_number),
    .record_crc   (record_crc),
    .computed_crc (computed_crc)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // bit-serial reflected crc, one data bit per step
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = {1'b0, r[15:1]};
      if (fb) r ^= CrcPoly;
    end
    return r;
  endfunction

  function automatic int unsigned cur_len();
    int unsigned n;
    n = (fmt_q == FmtShort) ? ShortDataBytes : LongDataBytes;
    if (n > MaxSectorBytesD) n = MaxSectorBytesD;
    return n;
  endfunction

  // classify one accepted byte and advance the mirrored record state
  function automatic sector_result_t predict_byte(input logic [7:0] b, input logic st);
    sector_result_t r;
    int unsigned    n;
    n        = cur_len();
    r.ob     = b;
    r.kind   = KIND_HEADER;
    r.last   = 1'b0;
    r.ok     = 1'b0;
    r.stored = '0;
    if (st) begin
      pos_q = 0;
      crc_q = CrcInit;
    end
    if (pos_q < HdrBytes) begin
      crc_q = crc_step(crc_q, b);
      if (pos_q == HdrBytes - 1) sec_q = b;
      pos_q++;
    end else if (pos_q < HdrBytes + n) begin
      r.ob   = b ^ DataMask;
      crc_q  = crc_step(crc_q, r.ob);
      r.kind = KIND_DATA;
      pos_q++;
    end else if (pos_q == HdrBytes + n) begin
      crc_hi_q = b;
      r.kind   = KIND_CRC;
      pos_q++;
    end else begin
      r.kind   = KIND_CRC;
      r.last   = 1'b1;
      r.stored = {crc_hi_q, b};
      r.ok     = (r.stored == crc_q);
    end
    r.sec = sec_q;
    r.crc = crc_q;
    if (r.last) begin
      pos_q = 0;
      crc_q = CrcInit;
    end
    return r;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // offer one byte, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic st);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      rec_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    rec_valid    <= 1'b1;
    rec_byte     <= b;
    record_start <= st;
    do @(posedge clk); while (!rec_ready);
    result_q.push_back(predict_byte(b, st));
    sent_items++;
    @(negedge clk);
  endtask

  // stop offering bytes until every expected result item has come back
  task automatic drain_results();
    rec_valid <= 1'b0;
    do @(negedge clk); while (result_q.size() != 0);
  endtask

  task automatic set_format(input logic [1:0] v);
    drain_results();
    repeat (2) @(negedge clk);
    cfg_valid     <= 1'b1;
    sector_format <= v;
    do @(posedge clk); while (!cfg_ready);
    fmt_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // build a record with a matching (or broken) crc and send part or all of it,
  // optionally rewriting the format register partway through
  task automatic send_record(input int dlen, input bit bad_crc, input int cut,
                             input int switch_at, input logic [1:0] switch_fmt);
    logic [7:0]  bytes_q[$];
    logic [15:0] crc;
    logic [7:0]  raw;
    logic        st;
    int          last;
    crc = CrcInit;
    bytes_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) :
                      ((fmt_q == FmtShort) ? 8'd2 : 8'd1));
    repeat (3) bytes_q.push_back(8'($urandom));
    foreach (bytes_q[i]) crc = crc_step(crc, bytes_q[i]);
    repeat (dlen) begin
      raw = 8'($urandom);
      bytes_q.push_back(raw);
      crc = crc_step(crc, raw ^ DataMask);
    end
    if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
    bytes_q.push_back(crc[15:8]);
    bytes_q.push_back(crc[7:0]);
    last = (cut < 0 || cut > bytes_q.size()) ? bytes_q.size() : cut;
    for (int i = 0; i < last; i++) begin
      if (i == switch_at) set_format(switch_fmt);
      // a record that follows a finished one may come without the start flag
      st = (i == 0) && ((pos_q != 0) || ($urandom_range(0, 1) == 1));
      send_byte(bytes_q[i], st);
    end
  endtask

  // header extremes, data unmasking and resync in the middle of a record
  task automatic test_header_resync();
    idle_on = 1'b0;
    send_byte(8'h00, 1'b1);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hB3, 1'b1);
  endtask

  // one complete short record with a matching crc
  task automatic test_full_records();
    idle_on = 1'b1;
    set_format(FmtShort);
    send_record(cur_len(), 1'b0, -1, -1, FmtShort);
  endtask

  // register values 0, 3 and 1, the two with no meaning included
  task automatic test_format_values();
    logic [1:0] vals[3];
    vals = '{2'd0, 2'd3, FmtReset};
    foreach (vals[i]) begin
      set_format(vals[i]);
      send_record(cur_len(), 1'b0, 5, -1, FmtShort);
    end
  endtask

  // length grows mid-record to a long one with a broken crc,
  // then shrinks once the position is past the short crc bytes
  task automatic test_midrecord_format();
    set_format(FmtShort);
    send_record(LongDataBytes, 1'b1, -1, 70, 2'd3);
    set_format(2'd0);
    send_record(LongDataBytes, 1'b0, 135, 134, FmtShort);
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    send_record(cur_len(), 1'b0, 24, -1, FmtShort);
    drain_results();
  endtask

  task automatic test_random_mix();
    int first;
    int pick;
    first = sent_items;
    while (sent_items - first < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 9);
      if (pick == 0)
        set_format(2'($urandom));
      else if (pick <= 6)
        send_record(cur_len(), 1'b0, $urandom_range(1, 12), -1, FmtShort);
      else
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_tail();
    idle_on = 1'b0;
    set_format(FmtShort);
    send_record(cur_len(), 1'b0, 12, -1, FmtShort);
    send_record(cur_len(), 1'b0, 12, -1, FmtShort);
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        res_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // compare each accepted result item with the oldest expectation
  always @(posedge clk) begin
    sector_result_t got;
    sector_result_t want;
    if (!rst && res_valid && res_ready) begin
      got.ob     = out_byte;
      got.kind   = byte_kind_t'(byte_kind);
      got.last   = record_end;
      got.ok     = crc_ok;
      got.sec    = sector_number;
      got.stored = record_crc;
      got.crc    = computed_crc;
      if (result_q.size() == 0) begin
        note_error("result item with none expected");
      end else begin
        want = result_q.pop_front();
        if (got.ob !== want.ob || got.kind !== want.kind || got.last !== want.last ||
            got.ok !== want.ok || got.sec !== want.sec || got.stored !== want.stored ||
            got.crc !== want.crc)
          note_error($sformatf({"mismatch: exp byte %h kind %0d end %b ok %b sec %h ",
                                "stored %h crc %h, got byte %h kind %0d end %b ok %b ",
                                "sec %h stored %h crc %h"},
                               want.ob, want.kind, want.last, want.ok, want.sec,
                               want.stored, want.crc, got.ob, got.kind, got.last,
                               got.ok, got.sec, got.stored, got.crc));
      end
    end
  end

  // run limit
  initial begin
    #1000000;
    $display("tb_disk_sector_record_checker: FAIL");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    sector_format = FmtReset;
    rec_valid     = 1'b0;
    rec_byte      = 8'h00;
    record_start  = 1'b0;
    fmt_q         = FmtReset;
    pos_q         = 0;
    crc_q         = CrcInit;
    crc_hi_q      = 8'h00;
    sec_q         = 8'h00;
    errors        = 0;
    sent_items    = 0;
    idle_on       = 1'b0;
    hold_req      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_header_resync();
    test_full_records();
    test_format_values();
    test_midrecord_format();
    test_backpressure();
    test_random_mix();
    test_tail();

    drain_results();
    repeat (4) @(negedge clk);
    if (errors == 0)
      $display("tb_disk_sector_record_checker: PASS");
    else
      $display("tb_disk_sector_record_checker: FAIL");
    $finish;
  end

endmodule
